FILE: rtl/sli_pkg.sv
// Shared types, constants and codes for the sorted insertion list.
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int TOTAL_W  = 5;

    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic {
        REQ_INSERT,
        REQ_DELETE
    } sli_req_t;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_FULL,
        ST_NOT_FOUND,
        ST_EMPTY
    } sli_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_LO_RD,
        S_LO_CAP,
        S_HI_CAP,
        S_OUT
    } sli_state_t;

    // Result of the shared comparator.
    typedef struct packed {
        logic lt;
        logic eq;
    } sli_cmp_t;

endpackage

FILE: rtl/sli_cmp.sv
// Shared signed magnitude and equality comparator for the list scan.
module sli_cmp
    import sli_pkg::*;
(
    input  data_t    a,
    input  data_t    b,
    output sli_cmp_t res
);

    // Signed order decides insert position; delete matches on exact bits.
    assign res.lt = (a < b);
    assign res.eq = (a == b);

endmodule

FILE: rtl/sorted_list_insert_delete.sv
// Top level of the sorted insertion list: sequencer, entry memory and result register.
//
//  Channel | Direction | Ports                                         | Handshake
//  --------+-----------+-----------------------------------------------+-----------------
//  s_      | in        | s_req_type, s_value                           | s_valid/s_ready
//  m_      | out       | m_status, m_entry_total, m_smallest, m_largest | m_valid/m_ready
//
// One request is handled at a time. The scan and the shift step through the entries
// one by one, using the entry memory, which has one write port and one registered
// read port, and the one comparator, which is used during the scan only.
// Reset (aresetn low, synchronous) clears the entry count, the sequencer and
// the result valid flag; the entries themselves are not cleared.
// A stalled result holds in the output register; s_ready only drops while a
// request is in progress.
module sorted_list_insert_delete
    import sli_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_req_type,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic [TOTAL_W-1:0]       m_entry_total,
    output logic signed [DATA_W-1:0] m_smallest,
    output logic signed [DATA_W-1:0] m_largest
);

    // Sequencer and control state.
    sli_state_t  state_reg, state_next;
    cnt_t        count_reg, count_next;
    logic        m_valid_reg, m_valid_next;

    // Working registers for the request in progress.
    sli_req_t    req_reg, req_next;
    data_t       val_reg, val_next;
    cnt_t        idx_reg, idx_next;
    cnt_t        pos_reg, pos_next;
    sli_status_t st_reg, st_next;
    data_t       lo_reg, lo_next;
    data_t       hi_reg, hi_next;

    // Result register.
    sli_status_t       m_status_reg, m_status_next;
    logic [TOTAL_W-1:0] m_total_reg, m_total_next;
    data_t             m_small_reg, m_small_next;
    data_t             m_large_reg, m_large_next;

    // Entry memory: one write and one registered read per cycle.
    data_t  mem [CAPACITY];
    data_t  rd_data_reg;
    addr_t  rd_addr;
    logic   mem_we;
    addr_t  mem_waddr;
    data_t  mem_wdata;

    sli_cmp_t cmp;
    sli_req_t s_req;
    cnt_t     idx_inc, idx_dec, count_dec, count_inc;

    assign s_req     = sli_req_t'(s_req_type);
    assign idx_inc   = idx_reg + cnt_t'(1);
    assign idx_dec   = idx_reg - cnt_t'(1);
    assign count_inc = count_reg + cnt_t'(1);
    assign count_dec = count_reg - cnt_t'(1);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // The single comparator looks at the entry just read against the request value.
    sli_cmp u_cmp (
        .a   (rd_data_reg),
        .b   (val_reg),
        .res (cmp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        st_reg       <= st_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        m_status_reg <= m_status_next;
        m_total_reg  <= m_total_next;
        m_small_reg  <= m_small_next;
        m_large_reg  <= m_large_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        req_next      = req_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        st_next       = st_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        m_status_next = m_status_reg;
        m_total_next  = m_total_reg;
        m_small_next  = m_small_reg;
        m_large_next  = m_large_reg;
        rd_addr       = '0;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[ADDR_W-1:0];
        mem_wdata     = rd_data_reg;

        // A taken result frees the output register.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_req;
                    val_next = s_value;
                    idx_next = '0;
                    st_next  = ST_DONE;
                    if (s_req == REQ_INSERT && count_reg == cnt_t'(CAPACITY)) begin
                        st_next    = ST_FULL;
                        state_next = S_LO_RD;
                    end else if (s_req == REQ_DELETE && count_reg == '0) begin
                        st_next    = ST_EMPTY;
                        state_next = S_LO_RD;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                rd_addr = idx_reg[ADDR_W-1:0];
                if (idx_reg == count_reg) begin
                    // Scan ran off the end of the list.
                    if (req_reg == REQ_INSERT) begin
                        pos_next   = idx_reg;
                        state_next = S_SHIFT_RD;
                    end else begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_LO_RD;
                    end
                end else begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if ((req_reg == REQ_INSERT && !cmp.lt) ||
                    (req_reg == REQ_DELETE && cmp.eq)) begin
                    pos_next   = idx_reg;
                    idx_next   = (req_reg == REQ_INSERT) ? count_reg : idx_reg;
                    state_next = S_SHIFT_RD;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (req_reg == REQ_INSERT) begin
                    // Open a gap at pos by moving entries up, top first.
                    if (idx_reg == pos_reg) begin
                        state_next = S_PLACE;
                    end else begin
                        rd_addr    = idx_dec[ADDR_W-1:0];
                        state_next = S_SHIFT_WR;
                    end
                end else begin
                    // Close the hole at pos by moving entries down.
                    if (idx_inc >= count_reg) begin
                        count_next = count_dec;
                        state_next = S_LO_RD;
                    end else begin
                        rd_addr    = idx_inc[ADDR_W-1:0];
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[ADDR_W-1:0];
                mem_wdata  = rd_data_reg;
                idx_next   = (req_reg == REQ_INSERT) ? idx_dec : idx_inc;
                state_next = S_SHIFT_RD;
            end
            S_PLACE: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[ADDR_W-1:0];
                mem_wdata  = val_reg;
                count_next = count_inc;
                state_next = S_LO_RD;
            end
            S_LO_RD: begin
                if (count_reg == '0) begin
                    lo_next    = '0;
                    hi_next    = '0;
                    state_next = S_OUT;
                end else begin
                    rd_addr    = '0;
                    state_next = S_LO_CAP;
                end
            end
            S_LO_CAP: begin
                lo_next    = rd_data_reg;
                rd_addr    = count_dec[ADDR_W-1:0];
                state_next = S_HI_CAP;
            end
            S_HI_CAP: begin
                hi_next    = rd_data_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                // Wait here until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_total_next  = TOTAL_W'(count_reg);
                    m_small_next  = lo_reg;
                    m_large_next  = hi_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_total = m_total_reg;
    assign m_smallest    = m_small_reg;
    assign m_largest     = m_large_reg;

endmodule

FILE: rtl/sli_checker.sv
// Port-level checks for the sorted insertion list, bound to the top level.
module sli_checker
    import sli_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [1:0]               m_status,
    input logic [TOTAL_W-1:0]       m_entry_total,
    input logic signed [DATA_W-1:0] m_smallest,
    input logic signed [DATA_W-1:0] m_largest
);

    // A reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Only one request is worked on at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // A dropped insert only happens on a full list.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> (m_entry_total == TOTAL_W'(CAPACITY)))
        else $error("full status with list not full");

    // An empty list reports zero bounds.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_entry_total == '0) |-> (m_smallest == '0 && m_largest == '0))
        else $error("nonzero bounds on empty list");

    // The smallest reported entry never lies above the largest.
    a_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_entry_total != '0) |-> (m_smallest <= m_largest))
        else $error("smallest above largest");

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_entry_total (m_entry_total),
    .m_smallest    (m_smallest),
    .m_largest     (m_largest)
);
